// ----- sv/bfct_pkg.sv -----
// Package for the box-filtered checker texture unit.
// Field widths, register reset value and default fraction width.
// No dependencies.
package bfct_pkg;

  localparam int COORD_W       = 32;
  localparam int BIAS_W        = 17;
  localparam int COV_W         = 17;
  localparam int WIDTH_W       = 31;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [BIAS_W-1:0] BIAS_RESET = 17'd655;

endpackage

// ----- sv/bfct_if.sv -----
// Valid/ready channels of the checker texture unit: texture word in, coverage word out.
// Depends on bfct_pkg for the field widths.
interface bfct_tex_if import bfct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] dx_u;
  logic signed [COORD_W-1:0] dx_v;
  logic signed [COORD_W-1:0] dy_u;
  logic signed [COORD_W-1:0] dy_v;

  modport source (output valid, coord_x, coord_y, dx_u, dx_v, dy_u, dy_v, input ready);
  modport sink   (input valid, coord_x, coord_y, dx_u, dx_v, dy_u, dy_v, output ready);
endinterface

interface bfct_cov_if import bfct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COV_W-1:0]  coverage;

  modport source (output valid, coverage, input ready);
  modport sink   (input valid, coverage, output ready);
endinterface

// ----- sv/bfct_axis.sv -----
// One axis of the checker filter: filter width, box integral of the triangle wave,
// and a pipelined restoring divider giving the signed axis term. Depends on bfct_pkg.
module bfct_axis import bfct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [BIAS_W-1:0]           bias_i,
  input  logic signed [COORD_W-1:0]   p_i,
  input  logic signed [COORD_W-1:0]   d1_i,
  input  logic signed [COORD_W-1:0]   d2_i,
  output logic signed [FRAC_BITS+1:0] term_o
);

  localparam int PW = FRAC_BITS + 2;      // period of 4.0 in Q.F
  localparam int DW = WIDTH_W + 1;        // divisor 2w
  localparam int CW = FRAC_BITS + 34;     // remainder and shifted divisor
  localparam int QW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 2;
  localparam int NS = FRAC_BITS + 2;      // overflow check plus QW quotient bits

  localparam logic [PW-1:0] TWO_ONE = PW'(1) << (FRAC_BITS + 1);
  localparam logic [QW-1:0] ONE_Q   = QW'(1) << FRAC_BITS;

  // stage A: filter width
  logic [COORD_W-1:0] m1, m2, mmax;
  logic [BIAS_W-1:0]  bias_eff;
  logic [COORD_W:0]   wsum;
  logic [WIDTH_W-1:0] w_d, w_a_q;
  logic [FRAC_BITS:0] p_a_q;

  assign m1       = d1_i[COORD_W-1] ? -d1_i : d1_i;
  assign m2       = d2_i[COORD_W-1] ? -d2_i : d2_i;
  assign mmax     = (m1 > m2) ? m1 : m2;
  assign bias_eff = (bias_i == '0) ? BIAS_W'(1) : bias_i;
  assign wsum     = {1'b0, mmax} + (COORD_W+1)'(bias_eff);
  assign w_d      = (wsum[COORD_W:WIDTH_W] != '0) ? '1 : wsum[WIDTH_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_a_q <= w_d;
      p_a_q <= p_i[FRAC_BITS:0];
    end
  end

  // stage B: window ends modulo the period
  logic [PW-1:0]      a_q, b_q;
  logic [WIDTH_W-1:0] w_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= {p_a_q, 1'b0} - w_a_q[PW-1:0];
      b_q   <= {p_a_q, 1'b0} + w_a_q[PW-1:0];
      w_b_q <= w_a_q;
    end
  end

  // stage C: integral difference, dividend and divisor
  logic [PW-1:0] ma, mb, nmag;
  logic          neg_c;

  assign ma    = (a_q >= TWO_ONE) ? a_q - TWO_ONE : TWO_ONE - a_q;
  assign mb    = (b_q >= TWO_ONE) ? b_q - TWO_ONE : TWO_ONE - b_q;
  assign neg_c = ma < mb;
  assign nmag  = neg_c ? mb - ma : ma - mb;

  logic [CW-1:0] rem_q [0:NS-1];
  logic [DW-1:0] den_q [0:NS-1];
  logic          neg_q [0:NS];
  logic          ovf_q [1:NS];
  logic [QW-1:0] quo_q [1:NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (CW'(nmag) << FRAC_BITS) + CW'(w_b_q);
      den_q[0] <= {w_b_q, 1'b0};
      neg_q[0] <= neg_c;
    end
  end

  // divider: first stage flags a quotient beyond range, then one bit per stage
  for (genvar j = 1; j <= NS; j++) begin : g_div
    localparam int K = FRAC_BITS + 2 - j;
    logic [CW-1:0] sh;
    logic          ge;

    assign sh = CW'(den_q[j-1]) << K;
    assign ge = rem_q[j-1] >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[j] <= neg_q[j-1];
      end
    end

    if (j == 1) begin : g_ovf
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ovf_q[j] <= ge;
          quo_q[j] <= '0;
          rem_q[j] <= rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ovf_q[j] <= ovf_q[j-1];
          quo_q[j] <= quo_q[j-1] | (ge ? (QW'(1) << K) : '0);
        end
      end
      if (j < NS) begin : g_pass
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[j] <= ge ? rem_q[j-1] - sh : rem_q[j-1];
            den_q[j] <= den_q[j-1];
          end
        end
      end
    end
  end

  // stage T: clamp and sign
  logic [QW-1:0]        mag_t;
  logic signed [TW-1:0] tpos, term_d, term_q;

  assign mag_t  = (ovf_q[NS] || quo_q[NS] > ONE_Q) ? ONE_Q : quo_q[NS];
  assign tpos   = signed'({1'b0, mag_t});
  assign term_d = neg_q[NS] ? -tpos : tpos;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

// ----- sv/box_filtered_checker_texture_unit.sv -----
// Box-filtered checkerboard texture unit: takes one texture word per cycle while not held
// and returns its coverage (default Q16.16 format). The pipeline depth is
// set by the per-axis restoring divider, which resolves one quotient bit per pipeline stage.
// The whole pipeline holds while a finished word is not taken; kernel_bias is written
// through cfg_we_i/cfg_wdata_i and resets to 655 (about 0.01).
// Depends on bfct_pkg, bfct_if and bfct_axis.
module box_filtered_checker_texture_unit import bfct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BIAS_W-1:0] cfg_wdata_i,
  bfct_tex_if.sink          tex_i,
  bfct_cov_if.source        cov_o
);

  localparam int TW  = FRAC_BITS + 2;
  localparam int PRW = 2 * TW;
  localparam int SW  = PRW - FRAC_BITS - 1;
  localparam int L   = FRAC_BITS + 6;     // axis pipeline depth
  localparam int LAT = L + 2;

  localparam logic signed [PRW-1:0] BASE = (PRW'(1) << (2 * FRAC_BITS)) + (PRW'(1) << FRAC_BITS);
  localparam logic [SW-1:0]         ONE_S = SW'(1) << FRAC_BITS;

  logic [BIAS_W-1:0] bias_q;
  logic [LAT-1:0]    v_q;
  logic              en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= BIAS_RESET;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  assign en          = !v_q[LAT-1] || cov_o.ready;
  assign tex_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], tex_i.valid};
    end
  end

  logic signed [TW-1:0] tu, tv;

  bfct_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_u (
    .clk_i  (clk_i),
    .en_i   (en),
    .bias_i (bias_q),
    .p_i    (tex_i.coord_x),
    .d1_i   (tex_i.dx_u),
    .d2_i   (tex_i.dy_u),
    .term_o (tu)
  );

  bfct_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_v (
    .clk_i  (clk_i),
    .en_i   (en),
    .bias_i (bias_q),
    .p_i    (tex_i.coord_y),
    .d1_i   (tex_i.dx_v),
    .d2_i   (tex_i.dy_v),
    .term_o (tv)
  );

  // product of the axis terms
  logic signed [PRW-1:0] prod_q, numv;
  logic [SW-1:0]         half;
  logic [FRAC_BITS:0]    cov_d;
  logic [COV_W-1:0]      cov_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PRW'(tu) * PRW'(tv);
    end
  end

  // 1/2 - tu*tv/2, rounded half up, clamped to 0..1
  assign numv  = BASE - prod_q;
  assign half  = numv[PRW-1:FRAC_BITS+1];
  assign cov_d = numv[PRW-1] ? '0 : (half > ONE_S) ? ONE_S[FRAC_BITS:0] : half[FRAC_BITS:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cov_q <= COV_W'(cov_d);
    end
  end

  assign cov_o.valid    = v_q[LAT-1];
  assign cov_o.coverage = cov_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for box_filtered_checker_texture_unit: directed table, then random words
// under several kernel_bias settings, checked against table values or Q16.16 box-filter model.
// Depends on bfct_pkg, bfct_if and the unit itself.
module tb;
  import bfct_pkg::*;

  localparam int     LAT      = FRAC_BITS_DEF + 8;
  localparam int     Q_ONE    = 1 << FRAC_BITS_DEF;
  localparam longint FX_ONE   = longint'(1) << FRAC_BITS_DEF;
  localparam longint W_SAT    = 64'sh7FFF_FFFF;
  localparam int     BY_MODEL = -1;
  localparam int     PHASE_N  = 217;

  localparam logic signed [COORD_W-1:0] ZERO  = 32'sh0000_0000;
  localparam logic signed [COORD_W-1:0] QTR   = 32'sh0000_4000;
  localparam logic signed [COORD_W-1:0] HALF  = 32'sh0000_8000;
  localparam logic signed [COORD_W-1:0] NHALF = 32'shFFFF_8000;
  localparam logic signed [COORD_W-1:0] ONEQ  = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] NONEQ = 32'shFFFF_0000;
  localparam logic signed [COORD_W-1:0] MINV  = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] MAXV  = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] dx_u;
    logic signed [COORD_W-1:0] dx_v;
    logic signed [COORD_W-1:0] dy_u;
    logic signed [COORD_W-1:0] dy_v;
  } tex_word_t;

  typedef struct packed {
    tex_word_t word;
    int        cov;
  } tex_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BIAS_W-1:0] cfg_wdata_i;
  logic [BIAS_W-1:0] bias_now;
  logic [COV_W-1:0]  coverage_due [$];
  int                mismatches = 0;
  int                tex_taken  = 0;

  bfct_tex_if tex_ch ();
  bfct_cov_if cov_ch ();

  box_filtered_checker_texture_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tex_i       (tex_ch.sink),
    .cov_o       (cov_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // per-axis box integral of the triangle wave, divided by the filter width
  function automatic longint box_term(input logic signed [COORD_W-1:0] p,
                                      input logic signed [COORD_W-1:0] d1,
                                      input logic signed [COORD_W-1:0] d2,
                                      input logic [BIAS_W-1:0] bias);
    longint pp, m1, m2, b, w, a, c, n, mask;
    longint unsigned numer, den, q;
    pp    = longint'(p);
    m1    = longint'(d1);
    m2    = longint'(d2);
    m1    = (m1 < 0) ? -m1 : m1;
    m2    = (m2 < 0) ? -m2 : m2;
    b     = longint'(bias);
    if (b == 0) b = 1;
    w     = ((m1 > m2) ? m1 : m2) + b;
    if (w > W_SAT) w = W_SAT;
    mask  = 4 * FX_ONE - 1;
    a     = (2 * pp - w) & mask;
    c     = (2 * pp + w) & mask;
    a     = a - 2 * FX_ONE;
    c     = c - 2 * FX_ONE;
    n     = ((a < 0) ? -a : a) - ((c < 0) ? -c : c);
    numer = longint'((n < 0) ? -n : n) * FX_ONE;
    den   = 2 * w;
    q     = (numer + den / 2) / den;
    if (q > FX_ONE) q = FX_ONE;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [COV_W-1:0] checker_coverage(input tex_word_t w,
                                                        input logic [BIAS_W-1:0] bias);
    longint tu, tv, num;
    tu  = box_term(w.coord_x, w.dx_u, w.dy_u, bias);
    tv  = box_term(w.coord_y, w.dx_v, w.dy_v, bias);
    num = FX_ONE * FX_ONE - tu * tv + FX_ONE;
    if (num < 0) num = 0;
    num = num / (2 * FX_ONE);
    if (num > FX_ONE) num = FX_ONE;
    return num[COV_W-1:0];
  endfunction

  function automatic tex_word_t mk(input logic signed [COORD_W-1:0] x, y, dxu, dxv, dyu, dyv);
    tex_word_t w;
    w.coord_x = x;
    w.coord_y = y;
    w.dx_u    = dxu;
    w.dx_v    = dxv;
    w.dy_u    = dyu;
    w.dy_v    = dyv;
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_deriv();
    int m;
    case ($urandom_range(0, 9))
      0: return ZERO;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? MINV : MAXV;
      default: begin
        m = int'($urandom_range(0, 2 * Q_ONE));
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  function automatic tex_word_t random_tex();
    return mk(rand_coord(), rand_coord(), rand_deriv(), rand_deriv(), rand_deriv(),
              rand_deriv());
  endfunction

  // mostly short gaps, a few long ones, now and then a run with none
  function automatic int draw_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic push_tex(input tex_word_t w, input int typed, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      tex_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    tex_ch.valid   = 1'b1;
    tex_ch.coord_x = w.coord_x;
    tex_ch.coord_y = w.coord_y;
    tex_ch.dx_u    = w.dx_u;
    tex_ch.dx_v    = w.dx_v;
    tex_ch.dy_u    = w.dy_u;
    tex_ch.dy_v    = w.dy_v;
    do @(posedge clk_i); while (tex_ch.ready !== 1'b1);
    if (typed == BY_MODEL) coverage_due.push_back(checker_coverage(w, bias_now));
    else coverage_due.push_back(COV_W'(typed));
    tex_taken++;
  endtask

  task automatic set_bias(input logic [BIAS_W-1:0] v);
    while (coverage_due.size() != 0) @(posedge clk_i);
    repeat (LAT) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    bias_now    = v;
  endtask

  always @(posedge clk_i) begin
    logic [COV_W-1:0] want;
    if (rst_ni === 1'b1 && cov_ch.valid === 1'b1 && cov_ch.ready === 1'b1) begin
      if (coverage_due.size() == 0) begin
        $error("coverage: no word expected, actual %0d", cov_ch.coverage);
        mismatches++;
      end else begin
        want = coverage_due.pop_front();
        if (cov_ch.coverage !== want) begin
          $error("coverage: expected %0d, actual %0d", want, cov_ch.coverage);
          mismatches++;
        end
      end
    end
  end

  // receiver; one long hold-off once the stream is well under way
  initial begin
    int quiet, stall;
    bit held;
    quiet = 0;
    held  = 1'b0;
    cov_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && tex_taken >= 400) begin
        held = 1'b1;
        cov_ch.ready = 1'b0;
        repeat (150) @(negedge clk_i);
      end
      stall = draw_gap(quiet);
      if (stall > 0) begin
        cov_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      cov_ch.ready = 1'b1;
    end
  end

  initial begin
    tex_row_t          dir_rows [17];
    logic [BIAS_W-1:0] bias_plan [6];
    int                send_quiet;
    send_quiet     = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    tex_ch.valid   = 1'b0;
    tex_ch.coord_x = '0;
    tex_ch.coord_y = '0;
    tex_ch.dx_u    = '0;
    tex_ch.dx_v    = '0;
    tex_ch.dy_u    = '0;
    tex_ch.dy_v    = '0;
    bias_now       = BIAS_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // runs at the reset bias; square centres give the known 0 and 1 values, the origin gives 1/2
    dir_rows = '{
      '{mk(ZERO,  ZERO,  ZERO, ZERO, ZERO, ZERO), 32768},
      '{mk(HALF,  HALF,  ZERO, ZERO, ZERO, ZERO), 0},
      '{mk(HALF,  NHALF, ZERO, ZERO, ZERO, ZERO), 65536},
      '{mk(NHALF, NHALF, ZERO, ZERO, ZERO, ZERO), 0},
      '{mk(32'sh0001_8000, HALF, ZERO, ZERO, ZERO, ZERO), 65536},
      '{mk(MAXV,  MINV,  ZERO, ZERO, ZERO, ZERO), BY_MODEL},
      '{mk(MINV,  MAXV,  ZERO, ZERO, ZERO, ZERO), BY_MODEL},
      '{mk(MINV,  MINV,  MINV, MINV, MINV, MINV), BY_MODEL},
      '{mk(MAXV,  MAXV,  MAXV, MAXV, MAXV, MAXV), BY_MODEL},
      '{mk(-1, -1, -1, -1, -1, -1), BY_MODEL},
      '{mk(HALF,  HALF,  MINV, MAXV, MAXV, MINV), BY_MODEL},
      '{mk(QTR,   QTR,   ONEQ, NONEQ, ZERO, ZERO), BY_MODEL},
      '{mk(HALF,  HALF,  -1, 1, 32'shFFFD_0000, ZERO), BY_MODEL},
      '{mk(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
           32'sh5555_5555, 32'sh5555_5555), BY_MODEL},
      '{mk(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
           32'shAAAA_AAAA, 32'shAAAA_AAAA), BY_MODEL},
      '{mk(HALF,  NHALF, ZERO, ZERO, 32'sh0001_8000, 32'shFFFF_C000), BY_MODEL},
      '{mk(ONEQ,  ZERO,  HALF, HALF, NHALF, HALF), BY_MODEL}
    };
    foreach (dir_rows[i]) push_tex(dir_rows[i].word, dir_rows[i].cov, draw_gap(send_quiet));

    // zero bias first: it must behave as one
    bias_plan = '{17'd0, 17'd1, 17'd65536, 17'h1FFFF,
                  BIAS_W'($urandom_range(2, 65535)), BIAS_RESET};
    foreach (bias_plan[k]) begin
      @(negedge clk_i);
      tex_ch.valid = 1'b0;
      set_bias(bias_plan[k]);
      repeat (PHASE_N) push_tex(random_tex(), BY_MODEL, draw_gap(send_quiet));
    end
    @(negedge clk_i);
    tex_ch.valid = 1'b0;

    while (coverage_due.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- box_filtered_checker_texture_unit.f -----
sv/bfct_pkg.sv
sv/bfct_if.sv
sv/bfct_axis.sv
sv/box_filtered_checker_texture_unit.sv
tb/tb.sv
